### src/bvl_pkg.sv
// ----------------------------------------------------------------------------
// bvl_pkg: shared types and constants of the bounded version list
// Entry layout, list depth, derived widths and command codes.
// ----------------------------------------------------------------------------
package bvl_pkg;

    // list geometry
    localparam int DEPTH   = 8;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    // fixed field widths
    localparam int CMD_W    = 2;
    localparam int VER_W    = 32;
    localparam int SIZE_W   = 16;
    localparam int HANDLE_W = 64;
    localparam int COUNT_W  = 4;
    localparam int BYTES_W  = 19;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    // one stored entry
    typedef struct packed {
        logic signed [VER_W-1:0] ver;
        logic [SIZE_W-1:0]       size;
        logic [HANDLE_W-1:0]     handle;
    } entry_t;

endpackage

### src/bounded_version_list.sv
// ----------------------------------------------------------------------------
// bounded_version_list: sorted list of versioned entries, newest first
// Add (replacing an equal version, evicting the oldest when full), floor get and
// count/bytes query, run by a small sequencer over a one-read, one-write memory.
// ----------------------------------------------------------------------------
// Flow: a query goes straight to the result; a get compares one entry per
//   cycle; an add does an eviction read when full, then a scan and a
//   one-entry-per-cycle shift that together visit at most DEPTH entries.
// Throughput: one request at a time; in_stall is high while a request runs.
//   A finished result waits in the output register while the next is taken.
// Reset: asynchronous; the list comes up empty, entries are not cleared.
module bounded_version_list
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [bvl_pkg::CMD_W-1:0]             command,
    input  logic signed [bvl_pkg::VER_W-1:0]      version,
    input  logic [bvl_pkg::SIZE_W-1:0]            value_size,
    input  logic [bvl_pkg::HANDLE_W-1:0]          value_handle,

    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  found,
    output logic signed [bvl_pkg::VER_W-1:0]      found_version,
    output logic [bvl_pkg::SIZE_W-1:0]            found_size,
    output logic [bvl_pkg::HANDLE_W-1:0]          found_handle,
    output logic [bvl_pkg::COUNT_W-1:0]           entry_count,
    output logic [bvl_pkg::BYTES_W-1:0]           stored_bytes
);

    localparam logic [bvl_pkg::IDX_W-1:0] LAST_IDX = bvl_pkg::IDX_W'(bvl_pkg::DEPTH - 1);
    localparam logic [bvl_pkg::CNT_W-1:0] FULL_CNT = bvl_pkg::CNT_W'(bvl_pkg::DEPTH);
    localparam logic [bvl_pkg::CNT_W-1:0] EVICT_CNT = bvl_pkg::CNT_W'(bvl_pkg::DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVICT,
        S_SCAN,
        S_SHIFT_RD,
        S_SHIFT,
        S_PUT,
        S_DONE
    } state_t;

    // sequencer and request registers
    state_t                            state_reg, state_next;
    logic [bvl_pkg::CMD_W-1:0]         cmd_reg, cmd_next;
    logic signed [bvl_pkg::VER_W-1:0]  ver_reg, ver_next;
    logic [bvl_pkg::SIZE_W-1:0]        size_reg, size_next;
    logic [bvl_pkg::HANDLE_W-1:0]      handle_reg, handle_next;
    logic [bvl_pkg::IDX_W-1:0]         scan_reg, scan_next;
    logic [bvl_pkg::IDX_W-1:0]         pos_reg, pos_next;
    logic [bvl_pkg::IDX_W-1:0]         shift_reg, shift_next;
    logic                              grow_reg, grow_next;
    logic                              hit_reg, hit_next;
    bvl_pkg::entry_t                   hit_entry_reg, hit_entry_next;

    // list totals
    logic [bvl_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic [bvl_pkg::BYTES_W-1:0]       bytes_reg, bytes_next;

    // output register
    logic                              out_valid_reg, out_valid_next;
    logic                              found_reg, found_next;
    bvl_pkg::entry_t                   found_entry_reg, found_entry_next;
    logic [bvl_pkg::COUNT_W-1:0]       count_out_reg, count_out_next;
    logic [bvl_pkg::BYTES_W-1:0]       bytes_out_reg, bytes_out_next;

    // entry memory
    bvl_pkg::entry_t                   mem [bvl_pkg::DEPTH];
    bvl_pkg::entry_t                   rdata_reg;
    logic [bvl_pkg::IDX_W-1:0]         raddr;
    logic                              mem_we;
    logic [bvl_pkg::IDX_W-1:0]         mem_waddr;
    bvl_pkg::entry_t                   mem_wdata;

    logic                              in_take;
    logic                              scan_last;
    bvl_pkg::entry_t                   new_entry;

    assign in_take   = in_valid && (state_reg == S_IDLE);
    assign scan_last = (bvl_pkg::CNT_W'(scan_reg) + bvl_pkg::CNT_W'(1)) == cnt_reg;
    assign new_entry = '{ver: ver_reg, size: size_reg, handle: handle_reg};

    // Read one entry and write one entry per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // Sequencer next-state logic
    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        ver_next         = ver_reg;
        size_next        = size_reg;
        handle_next      = handle_reg;
        scan_next        = scan_reg;
        pos_next         = pos_reg;
        shift_next       = shift_reg;
        grow_next        = grow_reg;
        hit_next         = hit_reg;
        hit_entry_next   = hit_entry_reg;
        cnt_next         = cnt_reg;
        bytes_next       = bytes_reg;
        found_next       = found_reg;
        found_entry_next = found_entry_reg;
        count_out_next   = count_out_reg;
        bytes_out_next   = bytes_out_reg;
        out_valid_next   = out_valid_reg && out_stall;
        raddr            = '0;
        mem_we           = 1'b0;
        mem_waddr        = pos_reg;
        mem_wdata        = new_entry;

        unique case (state_reg)
            S_IDLE:
            begin
                // latch the request and start the first read
                if (in_valid)
                begin
                    cmd_next       = command;
                    ver_next       = version;
                    size_next      = value_size;
                    handle_next    = value_handle;
                    scan_next      = '0;
                    pos_next       = '0;
                    grow_next      = 1'b0;
                    hit_next       = 1'b0;
                    hit_entry_next = '0;
                    case (command)
                        bvl_pkg::CMD_ADD:
                        begin
                            if (cnt_reg >= FULL_CNT)
                            begin
                                raddr      = LAST_IDX;
                                state_next = S_EVICT;
                            end
                            else if (cnt_reg == '0)
                            begin
                                grow_next  = 1'b1;
                                state_next = S_PUT;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        bvl_pkg::CMD_GET:
                        begin
                            state_next = (cnt_reg == '0) ? S_DONE : S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_EVICT:
            begin
                // drop the oldest entry, then scan from the head
                bytes_next = bytes_reg - bvl_pkg::BYTES_W'(rdata_reg.size);
                cnt_next   = EVICT_CNT;
                if (EVICT_CNT == '0)
                begin
                    grow_next  = 1'b1;
                    state_next = S_PUT;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // compare one entry per cycle, prefetch the next
                raddr = scan_reg + bvl_pkg::IDX_W'(1);
                if (cmd_reg == bvl_pkg::CMD_GET)
                begin
                    if (rdata_reg.ver <= ver_reg)
                    begin
                        hit_next       = 1'b1;
                        hit_entry_next = rdata_reg;
                        state_next     = S_DONE;
                    end
                    else if (scan_last)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        scan_next = scan_reg + bvl_pkg::IDX_W'(1);
                    end
                end
                else
                begin
                    if (ver_reg > rdata_reg.ver)
                    begin
                        pos_next   = scan_reg;
                        grow_next  = 1'b1;
                        state_next = S_SHIFT_RD;
                    end
                    else if (ver_reg == rdata_reg.ver)
                    begin
                        pos_next   = scan_reg;
                        grow_next  = 1'b0;
                        bytes_next = bytes_reg - bvl_pkg::BYTES_W'(rdata_reg.size);
                        state_next = S_PUT;
                    end
                    else if (scan_last)
                    begin
                        pos_next   = bvl_pkg::IDX_W'(cnt_reg);
                        grow_next  = 1'b1;
                        state_next = S_PUT;
                    end
                    else
                    begin
                        scan_next = scan_reg + bvl_pkg::IDX_W'(1);
                    end
                end
            end

            S_SHIFT_RD:
            begin
                // prime the shift with the tail entry
                raddr      = bvl_pkg::IDX_W'(cnt_reg - bvl_pkg::CNT_W'(1));
                shift_next = bvl_pkg::IDX_W'(cnt_reg);
                state_next = S_SHIFT;
            end

            S_SHIFT:
            begin
                // move entry down by one, walking toward the insert point
                mem_we     = 1'b1;
                mem_waddr  = shift_reg;
                mem_wdata  = rdata_reg;
                raddr      = shift_reg - bvl_pkg::IDX_W'(2);
                shift_next = shift_reg - bvl_pkg::IDX_W'(1);
                if ((shift_reg - bvl_pkg::IDX_W'(1)) == pos_reg)
                begin
                    state_next = S_PUT;
                end
            end

            S_PUT:
            begin
                // store the new entry and update totals
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = new_entry;
                bytes_next = bytes_reg + bvl_pkg::BYTES_W'(size_reg);
                cnt_next   = cnt_reg + bvl_pkg::CNT_W'(grow_reg);
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // hand the result to the output register once it is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    found_next       = hit_reg;
                    found_entry_next = hit_entry_reg;
                    count_out_next   = bvl_pkg::COUNT_W'(cnt_reg);
                    bytes_out_next   = bytes_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, totals and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cmd_reg         <= bvl_pkg::CMD_QUERY;
            ver_reg         <= '0;
            size_reg        <= '0;
            handle_reg      <= '0;
            scan_reg        <= '0;
            pos_reg         <= '0;
            shift_reg       <= '0;
            grow_reg        <= 1'b0;
            hit_reg         <= 1'b0;
            hit_entry_reg   <= '0;
            cnt_reg         <= '0;
            bytes_reg       <= '0;
            out_valid_reg   <= 1'b0;
            found_reg       <= 1'b0;
            found_entry_reg <= '0;
            count_out_reg   <= '0;
            bytes_out_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            cmd_reg         <= cmd_next;
            ver_reg         <= ver_next;
            size_reg        <= size_next;
            handle_reg      <= handle_next;
            scan_reg        <= scan_next;
            pos_reg         <= pos_next;
            shift_reg       <= shift_next;
            grow_reg        <= grow_next;
            hit_reg         <= hit_next;
            hit_entry_reg   <= hit_entry_next;
            cnt_reg         <= cnt_next;
            bytes_reg       <= bytes_next;
            out_valid_reg   <= out_valid_next;
            found_reg       <= found_next;
            found_entry_reg <= found_entry_next;
            count_out_reg   <= count_out_next;
            bytes_out_reg   <= bytes_out_next;
        end
    end

    // Drive the ports
    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign found_version = found_entry_reg.ver;
    assign found_size    = found_entry_reg.size;
    assign found_handle  = found_entry_reg.handle;
    assign entry_count   = count_out_reg;
    assign stored_bytes  = bytes_out_reg;

    // The list never holds more than DEPTH entries
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL_CNT)
        else $error("entry count above depth");

    // Writes stay inside the live list or one past its end
    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (bvl_pkg::CNT_W'(mem_waddr) <= cnt_reg))
        else $error("entry write beyond list end");

    // A new result only comes from the finishing step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside finishing step");

    // An accepted request always starts the sequencer
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg != S_IDLE))
        else $error("accepted request did not start");

    // A match can only come from a non-empty list
    a_hit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && found_reg) |-> (count_out_reg != '0))
        else $error("match reported on empty list");

endmodule
